// ===== rtl/core/bffu_pkg.sv =====
`default_nettype none
package bffu_pkg;

  localparam int unsigned DEF_FIFO_DEPTH = 256;

  localparam logic [7:0] HDR_BYTE  = 8'hAA;
  localparam logic [7:0] MARK_BYTE = 8'h01;
  localparam logic [7:0] END_BYTE  = 8'hFF;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } bffu_state_t;

  typedef enum logic [2:0] {
    POS_HDR,
    POS_MARK,
    POS_P1,
    POS_P2,
    POS_END
  } bffu_pos_t;

  // controller -> datapath
  typedef struct packed {
    logic do_push;   // store byte, push result
    logic push_err;  // push on full
    logic do_read;   // launch store read, advance read side
    logic pop_err;   // pop on empty
    logic do_frame;  // read data valid: run deframer, pop result
  } bffu_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
  } bffu_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/bffu_ctrl.sv =====
`default_nettype none
module bffu_ctrl
  import bffu_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire logic      in_cmd,
  input  wire bffu_sts_t sts,
  output logic           busy,
  output bffu_cmd_t      cmd
);

  bffu_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start && in_cmd == CMD_POP && !sts.empty) begin
          state_nxt = ST_POP;
        end
      end
      ST_POP:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_cmd == CMD_PUSH) begin
            cmd.do_push  = !sts.full;
            cmd.push_err = sts.full;
          end else begin
            cmd.do_read = !sts.empty;
            cmd.pop_err = sts.empty;
          end
        end
      end
      ST_POP: begin
        busy         = 1'b1;
        cmd.do_frame = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/bffu_dp.sv =====
`default_nettype none
module bffu_dp
  import bffu_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = DEF_FIFO_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire bffu_cmd_t  cmd,
  input  wire logic [7:0] in_byte_in,
  output bffu_sts_t       sts,
  output logic            out_valid,
  output logic            out_error_flag,
  output logic [7:0]      out_popped_byte,
  output logic            out_frame_done,
  output logic [7:0]      out_first_value,
  output logic [7:0]      out_second_value
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FIFO_DEPTH);

  logic [7:0] mem [FIFO_DEPTH];
  logic [7:0] rd_data_r;

  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  bffu_pos_t  pos_r, pos_nxt;
  logic [7:0] pay1_r, pay1_nxt;
  logic [7:0] pay2_r, pay2_nxt;
  logic       done;

  logic       valid_r;
  logic       err_r, err_nxt;
  logic [7:0] popped_r, popped_nxt;
  logic       fdone_r, fdone_nxt;
  logic [7:0] v1_r, v1_nxt;
  logic [7:0] v2_r, v2_nxt;
  logic       res_load;

  assign sts.full  = (cnt_r == FULL_CNT);
  assign sts.empty = (cnt_r == '0);

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.do_push) begin
      mem[wptr_r] <= in_byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_read) begin
      rd_data_r <= mem[rptr_r];
    end
  end

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (cmd.do_push) begin
      wptr_nxt = (wptr_r == LAST_PTR) ? '0 : wptr_r + 1'b1;
      cnt_nxt  = cnt_r + 1'b1;
    end else if (cmd.do_read) begin
      rptr_nxt = (rptr_r == LAST_PTR) ? '0 : rptr_r + 1'b1;
      cnt_nxt  = cnt_r - 1'b1;
    end
  end

  // deframer
  always_comb begin
    pos_nxt  = pos_r;
    pay1_nxt = pay1_r;
    pay2_nxt = pay2_r;
    done     = 1'b0;
    if (cmd.do_frame) begin
      case (pos_r)
        POS_MARK: pos_nxt = (rd_data_r == MARK_BYTE) ? POS_P1 : POS_HDR;
        POS_P1: begin
          pay1_nxt = rd_data_r;
          pos_nxt  = POS_P2;
        end
        POS_P2: begin
          pay2_nxt = rd_data_r;
          pos_nxt  = POS_END;
        end
        POS_END: begin
          done    = (rd_data_r == END_BYTE);
          pos_nxt = POS_HDR;
        end
        default: pos_nxt = (rd_data_r == HDR_BYTE) ? POS_MARK : POS_HDR;
      endcase
    end
  end

  assign res_load = cmd.do_push | cmd.push_err | cmd.pop_err | cmd.do_frame;

  always_comb begin
    err_nxt    = cmd.push_err | cmd.pop_err;
    popped_nxt = cmd.do_frame ? rd_data_r : 8'h00;
    fdone_nxt  = done;
    v1_nxt     = done ? pay1_r : 8'h00;
    v2_nxt     = done ? pay2_r : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      cnt_r   <= '0;
      pos_r   <= POS_HDR;
      pay1_r  <= 8'h00;
      pay2_r  <= 8'h00;
      valid_r <= 1'b0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      cnt_r   <= cnt_nxt;
      pos_r   <= pos_nxt;
      pay1_r  <= pay1_nxt;
      pay2_r  <= pay2_nxt;
      valid_r <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      err_r    <= err_nxt;
      popped_r <= popped_nxt;
      fdone_r  <= fdone_nxt;
      v1_r     <= v1_nxt;
      v2_r     <= v2_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_error_flag   = err_r;
  assign out_popped_byte  = popped_r;
  assign out_frame_done   = fdone_r;
  assign out_first_value  = v1_r;
  assign out_second_value = v2_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("fill count above depth");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == FULL_CNT) |-> wptr_r == rptr_r)
    else $error("pointers disagree with fill count");

  a_frame_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_frame |-> $past(cmd.do_read))
    else $error("deframer step without a store read");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_read |=> !valid_r)
    else $error("result strobe overlaps pop read");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/byte_fifo_with_frame_unpacker_unit.sv =====
`default_nettype none
// Push: result strobe in the cycle after accept; busy stays low, a new item may follow next cycle.
// Pop (non-empty): busy for one cycle while the registered store read completes;
//   result registered after the deframe step, so no new item is taken until busy falls.
// Pop on an empty FIFO: error result in the cycle after accept, no busy cycle.
// Each result strobes out_valid for one cycle; the receiver cannot stall.
// Synchronous active-low reset clears pointers, fill count and deframer; store is not cleared.
module byte_fifo_with_frame_unpacker_unit
  import bffu_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = DEF_FIFO_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // command side: item taken when start && !busy
  input  wire logic       start,
  output logic            busy,
  input  wire logic       in_cmd,
  input  wire logic [7:0] in_byte_in,
  // result side: one-cycle strobe
  output logic            out_valid,
  output logic            out_error_flag,
  output logic [7:0]      out_popped_byte,
  output logic            out_frame_done,
  output logic [7:0]      out_first_value,
  output logic [7:0]      out_second_value
);

  // Controller decides push/pop outcome from full/empty and sequences
  // the two-step pop (read launch, then deframe + result).
  bffu_cmd_t cmd;
  bffu_sts_t sts;

  bffu_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .sts    (sts),
    .busy   (busy),
    .cmd    (cmd)
  );

  // Datapath: byte store with wrap pointers and fill count, the
  // 0xAA / 0x01 / payload / payload / 0xFF deframer, and result registers.
  bffu_dp #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_byte_in       (in_byte_in),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_error_flag   (out_error_flag),
    .out_popped_byte  (out_popped_byte),
    .out_frame_done   (out_frame_done),
    .out_first_value  (out_first_value),
    .out_second_value (out_second_value)
  );

endmodule
`default_nettype wire

// ===== sim/byte_fifo_with_frame_unpacker_unit_test.sv =====
`timescale 1ns / 100ps

module byte_fifo_with_frame_unpacker_unit_test;
  import bffu_pkg::*;

  // One result per accepted item; all five fields are compared.
  typedef struct packed {
    logic       error_flag;
    logic [7:0] popped_byte;
    logic       frame_done;
    logic [7:0] first_value;
    logic [7:0] second_value;
  } frame_result_t;

  // Directed row. When pinned, the typed-in result is what gets checked.
  // Otherwise the predictor supplies it.
  typedef struct packed {
    logic          cmd;
    logic [7:0]    data;
    logic          pinned;
    frame_result_t res;
  } step_row_t;

  localparam int NUM_ROWS     = 19;
  localparam int TARGET_ITEMS = 950;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic       in_cmd;
  logic [7:0] in_byte_in;
  logic       out_valid;
  logic       out_error_flag;
  logic [7:0] out_popped_byte;
  logic       out_frame_done;
  logic [7:0] out_first_value;
  logic [7:0] out_second_value;

  // Predictor copy of the block state.
  logic [7:0] fifo_copy [0:DEF_FIFO_DEPTH-1];
  logic [7:0] wr_idx;
  logic [7:0] rd_idx;
  int         fill_level;
  bffu_pos_t  frame_pos;
  logic [7:0] pay_first;
  logic [7:0] pay_second;

  frame_result_t expected_results [$];
  int            fail_count;
  int            item_count;

  // Directed part: empty pop right after reset, one clean frame (payload at the
  // byte extremes), then the deframer recovery cases. The byte on a pop row
  // is ignored by the block, so it is set to all-ones there now and then.
  step_row_t directed_rows [0:NUM_ROWS-1] = '{
    // pop on empty FIFO right after reset: error, all else zero
    '{CMD_POP,  8'hFF, 1'b1, '{1'b1, 8'h00, 1'b0, 8'h00, 8'h00}},
    // clean frame, payload 0x00 / 0xFF
    '{CMD_PUSH, HDR_BYTE,  1'b1, '{1'b0, 8'h00, 1'b0, 8'h00, 8'h00}},
    '{CMD_PUSH, MARK_BYTE, 1'b1, '{1'b0, 8'h00, 1'b0, 8'h00, 8'h00}},
    '{CMD_PUSH, 8'h00,     1'b1, '{1'b0, 8'h00, 1'b0, 8'h00, 8'h00}},
    '{CMD_PUSH, 8'hFF,     1'b1, '{1'b0, 8'h00, 1'b0, 8'h00, 8'h00}},
    '{CMD_PUSH, END_BYTE,  1'b1, '{1'b0, 8'h00, 1'b0, 8'h00, 8'h00}},
    '{CMD_POP,  8'h00,     1'b1, '{1'b0, HDR_BYTE,  1'b0, 8'h00, 8'h00}},
    '{CMD_POP,  8'hFF,     1'b1, '{1'b0, MARK_BYTE, 1'b0, 8'h00, 8'h00}},
    '{CMD_POP,  8'h00,     1'b1, '{1'b0, 8'h00,     1'b0, 8'h00, 8'h00}},
    '{CMD_POP,  8'hFF,     1'b1, '{1'b0, 8'hFF,     1'b0, 8'h00, 8'h00}},
    '{CMD_POP,  8'h00,     1'b1, '{1'b0, END_BYTE,  1'b1, 8'h00, 8'hFF}},
    // junk at header slot, then header, header again (no recheck), marker
    '{CMD_PUSH, 8'h55,     1'b0, '0},
    '{CMD_PUSH, HDR_BYTE,  1'b0, '0},
    '{CMD_PUSH, HDR_BYTE,  1'b0, '0},
    '{CMD_PUSH, MARK_BYTE, 1'b0, '0},
    '{CMD_POP,  8'h00,     1'b0, '0},
    '{CMD_POP,  8'hFF,     1'b0, '0},
    '{CMD_POP,  8'h00,     1'b0, '0},
    '{CMD_POP,  8'hFF,     1'b0, '0}
  };

  byte_fifo_with_frame_unpacker_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_byte_in       (in_byte_in),
    .out_valid        (out_valid),
    .out_error_flag   (out_error_flag),
    .out_popped_byte  (out_popped_byte),
    .out_frame_done   (out_frame_done),
    .out_first_value  (out_first_value),
    .out_second_value (out_second_value)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Predicts one item and advances the predictor state.
  function automatic frame_result_t unpack_predict(input logic cmd, input logic [7:0] data);
    frame_result_t r;
    logic [7:0]    b;
    r = '0;
    if (cmd == CMD_PUSH) begin
      if (fill_level >= DEF_FIFO_DEPTH) begin
        r.error_flag = 1'b1;       // full: byte dropped, nothing moves
      end else begin
        fifo_copy[wr_idx] = data;
        wr_idx++;
        fill_level++;
      end
    end else if (fill_level == 0) begin
      r.error_flag = 1'b1;         // empty: nothing moves
    end else begin
      b = fifo_copy[rd_idx];
      rd_idx++;
      fill_level--;
      r.popped_byte = b;
      case (frame_pos)
        // a bad marker drops back to the header slot; the byte is not retried
        POS_MARK: frame_pos = (b == MARK_BYTE) ? POS_P1 : POS_HDR;
        POS_P1: begin
          pay_first = b;
          frame_pos = POS_P2;
        end
        POS_P2: begin
          pay_second = b;
          frame_pos  = POS_END;
        end
        POS_END: begin
          if (b == END_BYTE) begin
            r.frame_done   = 1'b1;
            r.first_value  = pay_first;
            r.second_value = pay_second;
          end
          frame_pos = POS_HDR;
        end
        default: frame_pos = (b == HDR_BYTE) ? POS_MARK : POS_HDR;
      endcase
    end
    return r;
  endfunction

  // Offers one item starting at a falling edge and returns at the falling edge
  // after it was taken, with start still high so a back-to-back item can follow.
  // Items 120..279 run with no idle gaps.
  task automatic send_item(input logic cmd, input logic [7:0] data, input logic pinned,
                           input frame_result_t typed);
    frame_result_t predicted;
    if (!(item_count >= 120 && item_count < 280) && $urandom_range(0, 99) < 26) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start      = 1'b1;
    in_cmd     = cmd;
    in_byte_in = data;
    do @(posedge clk); while (busy);
    predicted = unpack_predict(cmd, data);
    expected_results.push_back(pinned ? typed : predicted);
    item_count++;
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Results are strobed for one cycle; compare each against the oldest prediction.
  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual err=%0b byte=0x%0h done=%0b",
                 $time, out_error_flag, out_popped_byte, out_frame_done);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("error_flag",   want.error_flag,   out_error_flag);
        check_field("popped_byte",  want.popped_byte,  out_popped_byte);
        check_field("frame_done",   want.frame_done,   out_frame_done);
        check_field("first_value",  want.first_value,  out_first_value);
        check_field("second_value", want.second_value, out_second_value);
      end
    end
  end

  initial begin : stimulus
    logic [7:0] pending_bytes [$];
    logic [7:0] frame [0:4];
    logic       filled;
    int         n_frames;
    int         k;
    int         waited;

    rst_n      = 1'b0;
    start      = 1'b0;
    in_cmd     = CMD_PUSH;
    in_byte_in = 8'h00;
    fail_count = 0;
    item_count = 0;
    filled     = 1'b0;
    wr_idx     = '0;
    rd_idx     = '0;
    fill_level = 0;
    frame_pos  = POS_HDR;
    pay_first  = '0;
    pay_second = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].cmd, directed_rows[i].data, directed_rows[i].pinned,
                directed_rows[i].res);

    // Random part: mostly well-formed frames with random payload, some broken
    // frames and junk, plus one pass that runs the FIFO full and back to empty.
    while (item_count < TARGET_ITEMS) begin
      if (!filled && item_count > 300) begin
        filled = 1'b1;
        // back-to-back frames until full, then pushes that must be refused
        k = 0;
        while (fill_level < DEF_FIFO_DEPTH) begin
          case (k % 5)
            0:       send_item(CMD_PUSH, HDR_BYTE, 1'b0, '0);
            1:       send_item(CMD_PUSH, MARK_BYTE, 1'b0, '0);
            4:       send_item(CMD_PUSH, END_BYTE, 1'b0, '0);
            default: send_item(CMD_PUSH, 8'($urandom), 1'b0, '0);
          endcase
          k++;
        end
        repeat (3) send_item(CMD_PUSH, 8'($urandom), 1'b0, '0);
        // drain through the deframer, then one pop on empty
        while (fill_level > 0) send_item(CMD_POP, 8'($urandom), 1'b0, '0);
        send_item(CMD_POP, 8'($urandom), 1'b0, '0);
      end else if ($urandom_range(0, 9) < 8) begin
        // one to three frames, some with a leading junk byte or a corrupted
        // header, marker or end byte
        pending_bytes.delete();
        n_frames = $urandom_range(1, 3);
        repeat (n_frames) begin
          if ($urandom_range(0, 3) == 0) pending_bytes.push_back(8'($urandom));
          frame[0] = HDR_BYTE;
          frame[1] = MARK_BYTE;
          frame[2] = 8'($urandom);
          frame[3] = 8'($urandom);
          frame[4] = END_BYTE;
          if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 2))
              0:       frame[0] = 8'($urandom);
              1:       frame[1] = 8'($urandom);
              default: frame[4] = 8'($urandom);
            endcase
          end
          foreach (frame[j]) pending_bytes.push_back(frame[j]);
        end
        // pushes and pops interleaved; a pop may find the FIFO empty
        while (pending_bytes.size() != 0 || fill_level > 0) begin
          if (pending_bytes.size() != 0 && $urandom_range(0, 99) < 60)
            send_item(CMD_PUSH, pending_bytes.pop_front(), 1'b0, '0);
          else
            send_item(CMD_POP, 8'($urandom), 1'b0, '0);
        end
        if ($urandom_range(0, 2) == 0) send_item(CMD_POP, 8'($urandom), 1'b0, '0);
      end else begin
        // junk: random commands and bytes
        repeat (12) send_item(1'($urandom), 8'($urandom), 1'b0, '0);
      end
    end

    start = 1'b0;

    // The latest result comes after a pop's store read and deframe step; allow ample slack.
    waited = 0;
    while (expected_results.size() != 0 && waited < 100) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results missing, expected 0 outstanding, actual %0d",
               $time, expected_results.size(), expected_results.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under 200 us.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
